FILE: design/gmds_pkg.sv
`default_nettype none

package gmds_pkg;

  // item field widths
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 10;
  localparam int DIRS_W = 4;
  localparam int MARK_W = 2;
  localparam int LEN_W  = 11;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 3'd5;

  localparam logic [5:0] RST_GRID_COLS = 6'd32;
  localparam logic [5:0] RST_GRID_ROWS = 6'd32;
  localparam logic [4:0] RST_START_COL = 5'd0;
  localparam logic [4:0] RST_START_ROW = 5'd0;
  localparam logic [4:0] RST_GOAL_COL  = 5'd31;
  localparam logic [4:0] RST_GOAL_ROW  = 5'd31;

  // item functions
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  // cell marks
  localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
  localparam logic [MARK_W-1:0] MARK_DONE = 2'd1;
  localparam logic [MARK_W-1:0] MARK_PATH = 2'd2;

  // directions, also the bit positions in open_dirs
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

endpackage

`default_nettype wire

FILE: design/grid_maze_dfs_solver.sv
`default_nettype none

// Grid maze solver, depth-first search over cell memories.
// Items: pulse start with func, cell_index and open_dirs while busy is low;
// the item is taken at that edge. Every item gives one result: done is high
// for one cycle with cell_mark, found and path_length. Results cannot be held.
// Load writes one cell's passages; its result comes in the cycle after the item.
// Read returns one cell's mark, registered out of the mark memory in the READ state.
// Clear sweeps the mark memory, one cell per cycle, and then gives its result.
// found and path_length are kept.
// Run: the INIT state marks and pushes the start cell; then the PASS state
// reads the top cell's passages, the TEST state tests open neighbors one at
// a time, north first, and pushes the first free one, and on a dead end the top
// is dropped and the POP state reloads the cell below. Each return to a cell
// rescans it from north; the single mark read port allows one test a cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while no item is in progress, the block does not enforce it.
// Reset loads the configuration defaults, clears found and the depth and
// starts a clearing pass over every cell of the mark memory,
// with busy high; configuration writes are taken during it.
module grid_maze_dfs_solver #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [gmds_pkg::FUNC_W-1:0]       func,
  input  wire logic [gmds_pkg::IDX_W-1:0]        cell_index,
  input  wire logic [gmds_pkg::DIRS_W-1:0]       open_dirs,
  output logic                                   done,
  output logic      [gmds_pkg::MARK_W-1:0]       cell_mark,
  output logic                                   found,
  output logic      [gmds_pkg::LEN_W-1:0]        path_length,
  input  wire logic                              cfg_we,
  input  wire logic [gmds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gmds_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NCELLS = MAX_COLS * MAX_ROWS;
  localparam int CB     = $clog2(MAX_COLS);
  localparam int RB     = $clog2(MAX_ROWS);
  localparam int AW     = $clog2(NCELLS);
  localparam int DW     = $clog2(NCELLS + 1);
  localparam int CNW    = $clog2(MAX_COLS + 1);
  localparam int RNW    = $clog2(MAX_ROWS + 1);
  localparam int SW     = RB + CB;
  localparam int LW     = gmds_pkg::LEN_W;
  localparam int MW     = gmds_pkg::MARK_W;
  localparam int PW     = gmds_pkg::DIRS_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_INIT  = 3'd3;
  localparam logic [2:0] ST_PASS  = 3'd4;
  localparam logic [2:0] ST_TEST  = 3'd5;
  localparam logic [2:0] ST_POP   = 3'd6;

  // configuration registers
  logic [5:0] grid_cols;
  logic [5:0] grid_rows;
  logic [4:0] start_col;
  logic [4:0] start_row;
  logic [4:0] goal_col;
  logic [4:0] goal_row;

  // control and search state
  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic          clr_reply;
  logic          rd_ok;
  logic          found_flag;
  logic [DW-1:0] depth;
  logic [RB-1:0] top_row;
  logic [CB-1:0] top_col;
  logic [AW-1:0] top_addr;
  logic [PW-1:0] cand_left;
  logic [1:0]    pend_dir;

  // memory ports
  logic          pass_we;
  logic [AW-1:0] pass_waddr;
  logic [AW-1:0] pass_raddr;
  logic [PW-1:0] pass_rdata;
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  logic [MW-1:0] mark_wdata;
  logic [AW-1:0] mark_raddr;
  logic [MW-1:0] mark_rdata;
  logic          stack_we;
  logic [AW-1:0] stack_waddr;
  logic [SW-1:0] stack_wdata;
  logic [AW-1:0] stack_raddr;
  logic [SW-1:0] stack_rdata;

  // datapath
  logic          accept;
  logic          idx_ok;
  logic [CNW-1:0] cols;
  logic [RNW-1:0] rows;
  logic          start_ok;
  logic          goal_ok;
  logic [RB-1:0] start_r;
  logic [CB-1:0] start_c;
  logic [AW-1:0] start_addr;
  logic          start_goal;
  logic [PW-1:0] scan_mask;
  logic [PW-1:0] cand;
  logic          cand_any;
  logic [1:0]    first_dir;
  logic [1:0]    sel_dir;
  logic [RB-1:0] nb_row;
  logic [CB-1:0] nb_col;
  logic [AW-1:0] nb_addr;
  logic          nb_goal;
  logic          mark_free;
  logic          do_push;
  logic          do_pop;
  logic          do_scan;
  logic [RB-1:0] pop_row;
  logic [CB-1:0] pop_col;
  logic [AW-1:0] pop_addr;
  logic [DW-1:0] depth_m2;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign idx_ok      = (32'(cell_index) < NCELLS);
  assign found       = found_flag;
  assign path_length = LW'(depth);

  // grid size saturated into the supported range
  always_comb begin
    if (grid_cols == '0) begin
      cols = CNW'(1);
    end else if (32'(grid_cols) > MAX_COLS) begin
      cols = CNW'(MAX_COLS);
    end else begin
      cols = CNW'(grid_cols);
    end
    if (grid_rows == '0) begin
      rows = RNW'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      rows = RNW'(MAX_ROWS);
    end else begin
      rows = RNW'(grid_rows);
    end
  end

  // start and finish cells
  always_comb begin
    start_ok   = (32'(start_col) < 32'(cols)) && (32'(start_row) < 32'(rows));
    goal_ok    = (32'(goal_col) < 32'(cols)) && (32'(goal_row) < 32'(rows));
    start_r    = RB'(start_row);
    start_c    = CB'(start_col);
    start_addr = AW'(32'(start_r) * MAX_COLS + 32'(start_c));
    start_goal = goal_ok && (start_r == RB'(goal_row)) && (start_c == CB'(goal_col));
  end

  // neighbor scan: passages fresh from memory, then what is left to try
  assign scan_mask = (state == ST_PASS) ? pass_rdata : cand_left;

  gmds_nbr #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_nbr (
    .top_row  (top_row),
    .top_col  (top_col),
    .top_addr (top_addr),
    .cols     (cols),
    .rows     (rows),
    .open_mask(scan_mask),
    .sel_dir  (sel_dir),
    .cand     (cand),
    .nb_row   (nb_row),
    .nb_col   (nb_col),
    .nb_addr  (nb_addr)
  );

  // first candidate in the order north, south, east, west
  always_comb begin
    cand_any = |cand;
    if (cand[gmds_pkg::DIR_N]) begin
      first_dir = gmds_pkg::DIR_N;
    end else if (cand[gmds_pkg::DIR_S]) begin
      first_dir = gmds_pkg::DIR_S;
    end else if (cand[gmds_pkg::DIR_E]) begin
      first_dir = gmds_pkg::DIR_E;
    end else begin
      first_dir = gmds_pkg::DIR_W;
    end
  end

  // step decision
  always_comb begin
    mark_free = (mark_rdata == gmds_pkg::MARK_FREE);
    do_push   = (state == ST_TEST) && mark_free;
    do_scan   = ((state == ST_PASS) || ((state == ST_TEST) && !mark_free)) && cand_any;
    do_pop    = ((state == ST_PASS) || ((state == ST_TEST) && !mark_free)) && !cand_any;
    sel_dir   = do_push ? pend_dir : first_dir;
    nb_goal   = goal_ok && (nb_row == RB'(goal_row)) && (nb_col == CB'(goal_col));
    pop_row   = stack_rdata[SW-1:CB];
    pop_col   = stack_rdata[CB-1:0];
    pop_addr  = AW'(32'(pop_row) * MAX_COLS + 32'(pop_col));
    depth_m2  = depth - DW'(2);
  end

  // passage memory ports
  always_comb begin
    pass_we    = accept && (func == gmds_pkg::FUNC_LOAD) && idx_ok;
    pass_waddr = AW'(cell_index);
    case (state)
      ST_INIT: pass_raddr = start_addr;
      ST_TEST: pass_raddr = nb_addr;
      ST_POP:  pass_raddr = pop_addr;
      default: pass_raddr = top_addr;
    endcase
  end

  // mark memory ports; where a write and a read meet on one entry, the read gets the old mark
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = top_addr;
    mark_wdata = gmds_pkg::MARK_DONE;
    if (state == ST_CLEAR) begin
      mark_we    = 1'b1;
      mark_waddr = clr_addr;
      mark_wdata = gmds_pkg::MARK_FREE;
    end else if ((state == ST_INIT) && start_ok) begin
      mark_we    = 1'b1;
      mark_waddr = start_addr;
      mark_wdata = gmds_pkg::MARK_PATH;
    end else if (do_push) begin
      mark_we    = 1'b1;
      mark_waddr = nb_addr;
      mark_wdata = gmds_pkg::MARK_PATH;
    end else if (do_pop) begin
      mark_we    = 1'b1;
    end
    mark_raddr = (state == ST_IDLE) ? AW'(cell_index) : nb_addr;
  end

  // stack memory ports
  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = depth[AW-1:0];
    stack_wdata = {nb_row, nb_col};
    if ((state == ST_INIT) && start_ok) begin
      stack_we    = 1'b1;
      stack_waddr = '0;
      stack_wdata = {start_r, start_c};
    end else if (do_push) begin
      stack_we    = 1'b1;
    end
    stack_raddr = depth_m2[AW-1:0];
  end

  gmds_ram #(.WIDTH(PW), .DEPTH(NCELLS)) u_pass_ram (
    .clk  (clk),
    .we   (pass_we),
    .waddr(pass_waddr),
    .wdata(open_dirs),
    .raddr(pass_raddr),
    .rdata(pass_rdata)
  );

  gmds_ram #(.WIDTH(MW), .DEPTH(NCELLS)) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_waddr),
    .wdata(mark_wdata),
    .raddr(mark_raddr),
    .rdata(mark_rdata)
  );

  gmds_ram #(.WIDTH(SW), .DEPTH(NCELLS)) u_stack_ram (
    .clk  (clk),
    .we   (stack_we),
    .waddr(stack_waddr),
    .wdata(stack_wdata),
    .raddr(stack_raddr),
    .rdata(stack_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= gmds_pkg::RST_GRID_COLS;
      grid_rows <= gmds_pkg::RST_GRID_ROWS;
      start_col <= gmds_pkg::RST_START_COL;
      start_row <= gmds_pkg::RST_START_ROW;
      goal_col  <= gmds_pkg::RST_GOAL_COL;
      goal_row  <= gmds_pkg::RST_GOAL_ROW;
    end else if (cfg_we) begin
      case (cfg_index)
        gmds_pkg::CFG_GRID_COLS: grid_cols <= cfg_data;
        gmds_pkg::CFG_GRID_ROWS: grid_rows <= cfg_data;
        gmds_pkg::CFG_START_COL: start_col <= cfg_data[4:0];
        gmds_pkg::CFG_START_ROW: start_row <= cfg_data[4:0];
        gmds_pkg::CFG_GOAL_COL:  goal_col  <= cfg_data[4:0];
        gmds_pkg::CFG_GOAL_ROW:  goal_row  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      done       <= 1'b0;
      found_flag <= 1'b0;
      depth      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cell_mark <= gmds_pkg::MARK_FREE;
            case (func)
              gmds_pkg::FUNC_LOAD: begin
                done <= 1'b1;
              end
              gmds_pkg::FUNC_CLEAR: begin
                state     <= ST_CLEAR;
                clr_addr  <= '0;
                clr_reply <= 1'b1;
              end
              gmds_pkg::FUNC_RUN: begin
                state <= ST_INIT;
              end
              gmds_pkg::FUNC_READ: begin
                rd_ok <= idx_ok;
                state <= ST_READ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (clr_addr == AW'(NCELLS - 1)) begin
            state <= ST_IDLE;
            done  <= clr_reply;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_READ: begin
          cell_mark <= rd_ok ? mark_rdata : gmds_pkg::MARK_FREE;
          done      <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_INIT: begin
          found_flag <= 1'b0;
          if (!start_ok) begin
            depth <= '0;
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            depth    <= DW'(1);
            top_row  <= start_r;
            top_col  <= start_c;
            top_addr <= start_addr;
            if (start_goal) begin
              found_flag <= 1'b1;
              done       <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              state <= ST_PASS;
            end
          end
        end
        ST_PASS, ST_TEST: begin
          if (do_push) begin
            depth    <= depth + DW'(1);
            top_row  <= nb_row;
            top_col  <= nb_col;
            top_addr <= nb_addr;
            if (nb_goal) begin
              found_flag <= 1'b1;
              done       <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              state <= ST_PASS;
            end
          end else if (do_scan) begin
            cand_left <= cand & ~(PW'(1) << first_dir);
            pend_dir  <= first_dir;
            state     <= ST_TEST;
          end else begin
            // dead end: drop the top
            depth <= depth - DW'(1);
            if (depth == DW'(1)) begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              state <= ST_POP;
            end
          end
        end
        ST_POP: begin
          top_row  <= pop_row;
          top_col  <= pop_col;
          top_addr <= pop_addr;
          state    <= ST_PASS;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(NCELLS))
    else $error("stack depth beyond cell count");

  a_found_depth: assert property (@(posedge clk) disable iff (rst)
    found_flag |-> (depth != '0))
    else $error("found with empty stack");

  a_search_depth: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_PASS) || (state == ST_TEST) || (state == ST_POP)) |-> (depth != '0))
    else $error("search step with empty stack");

  a_item_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (func != gmds_pkg::FUNC_LOAD)) |=> busy)
    else $error("multi-cycle item did not hold busy");

  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CLEAR) && (clr_addr == AW'(NCELLS - 1)))
      |=> ((state == ST_IDLE) && (done == $past(clr_reply))))
    else $error("clearing pass did not end cleanly");

endmodule

`default_nettype wire

FILE: design/gmds_ram.sv
`default_nettype none

module gmds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/gmds_nbr.sv
`default_nettype none

module gmds_nbr #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  wire logic [$clog2(MAX_ROWS)-1:0]          top_row,
  input  wire logic [$clog2(MAX_COLS)-1:0]          top_col,
  input  wire logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] top_addr,
  input  wire logic [$clog2(MAX_COLS+1)-1:0]        cols,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]        rows,
  input  wire logic [gmds_pkg::DIRS_W-1:0]          open_mask,
  input  wire logic [1:0]                           sel_dir,
  output logic      [gmds_pkg::DIRS_W-1:0]          cand,
  output logic      [$clog2(MAX_ROWS)-1:0]          nb_row,
  output logic      [$clog2(MAX_COLS)-1:0]          nb_col,
  output logic      [$clog2(MAX_COLS*MAX_ROWS)-1:0] nb_addr
);

  localparam int CB = $clog2(MAX_COLS);
  localparam int RB = $clog2(MAX_ROWS);
  localparam int AW = $clog2(MAX_COLS * MAX_ROWS);

  logic [gmds_pkg::DIRS_W-1:0] in_grid;

  // passages leading off the grid in use count as closed
  always_comb begin
    in_grid[gmds_pkg::DIR_N] = (top_row != '0);
    in_grid[gmds_pkg::DIR_S] = ((32'(top_row) + 32'd1) < 32'(rows));
    in_grid[gmds_pkg::DIR_E] = ((32'(top_col) + 32'd1) < 32'(cols));
    in_grid[gmds_pkg::DIR_W] = (top_col != '0);
    cand = open_mask & in_grid;
  end

  // coordinates and address of the neighbor in the selected direction
  always_comb begin
    nb_row  = top_row;
    nb_col  = top_col;
    nb_addr = top_addr;
    case (sel_dir)
      gmds_pkg::DIR_N: begin
        nb_row  = top_row - RB'(1);
        nb_addr = top_addr - AW'(MAX_COLS);
      end
      gmds_pkg::DIR_S: begin
        nb_row  = top_row + RB'(1);
        nb_addr = top_addr + AW'(MAX_COLS);
      end
      gmds_pkg::DIR_E: begin
        nb_col  = top_col + CB'(1);
        nb_addr = top_addr + AW'(1);
      end
      gmds_pkg::DIR_W: begin
        nb_col  = top_col - CB'(1);
        nb_addr = top_addr - AW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int GRID_W       = 32;
  localparam int GRID_H       = 32;
  localparam int NCELLS       = GRID_W * GRID_H;
  localparam int RANDOM_ITEMS = 120;
  localparam int PHASE_ITEMS  = 16;
  localparam int STALL_LIMIT  = 100000;

  typedef struct packed {
    logic [gmds_pkg::MARK_W-1:0] mark;
    logic                        hit;
    logic [gmds_pkg::LEN_W-1:0]  depth;
  } outcome_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  logic [gmds_pkg::FUNC_W-1:0]     func = gmds_pkg::FUNC_LOAD;
  logic [gmds_pkg::IDX_W-1:0]      cell_index = '0;
  logic [gmds_pkg::DIRS_W-1:0]     open_dirs = '0;
  logic                            done;
  logic [gmds_pkg::MARK_W-1:0]     cell_mark;
  logic                            found;
  logic [gmds_pkg::LEN_W-1:0]      path_length;
  logic                            cfg_we = 1'b0;
  logic [gmds_pkg::CFG_IDX_W-1:0]  cfg_index = gmds_pkg::CFG_GRID_COLS;
  logic [gmds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // maze state mirrored by the testbench
  logic [5:0]                  cols_cfg = gmds_pkg::RST_GRID_COLS;
  logic [5:0]                  rows_cfg = gmds_pkg::RST_GRID_ROWS;
  logic [4:0]                  start_col_cfg = gmds_pkg::RST_START_COL;
  logic [4:0]                  start_row_cfg = gmds_pkg::RST_START_ROW;
  logic [4:0]                  goal_col_cfg = gmds_pkg::RST_GOAL_COL;
  logic [4:0]                  goal_row_cfg = gmds_pkg::RST_GOAL_ROW;
  logic [gmds_pkg::DIRS_W-1:0] wall_bits [0:NCELLS-1];
  logic [gmds_pkg::MARK_W-1:0] mark_bits [0:NCELLS-1];
  int                          dfs_stack [0:NCELLS];
  int                          dfs_depth = 0;
  logic                        goal_hit = 1'b0;
  bit                          walls_known [0:NCELLS-1];

  outcome_t pending_outcomes [$];

  int items_sent = 0;
  int random_items = 0;
  int searches = 0;
  int goal_searches = 0;
  int settings_used = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  grid_maze_dfs_solver dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .cell_index (cell_index),
    .open_dirs  (open_dirs),
    .done       (done),
    .cell_mark  (cell_mark),
    .found      (found),
    .path_length(path_length),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    foreach (wall_bits[i]) begin
      wall_bits[i] = '0;
      mark_bits[i] = gmds_pkg::MARK_FREE;
      walls_known[i] = 1'b0;
    end
  end

  // grid size in use, saturated into 1..32
  function automatic int eff_dim(logic [5:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // neighbor reached through an open passage, or -1 when closed, off the grid or marked
  function automatic int open_neighbor(int r, int c, logic [1:0] d, int ncols, int nrows);
    int nr;
    int nc;
    nr = r;
    nc = c;
    if (!wall_bits[r*GRID_W + c][d]) return -1;
    case (d)
      gmds_pkg::DIR_N: begin
        if (r == 0) return -1;
        nr = r - 1;
      end
      gmds_pkg::DIR_S: begin
        if (r + 1 >= nrows) return -1;
        nr = r + 1;
      end
      gmds_pkg::DIR_E: begin
        if (c + 1 >= ncols) return -1;
        nc = c + 1;
      end
      default: begin
        if (c == 0) return -1;
        nc = c - 1;
      end
    endcase
    if (mark_bits[nr*GRID_W + nc] != gmds_pkg::MARK_FREE) return -1;
    return nr*GRID_W + nc;
  endfunction

  // depth-first search from start to goal over the mirrored maze
  function automatic void run_dfs();
    int ncols;
    int nrows;
    int goal;
    int top;
    int nxt;
    int d;
    bit goal_ok;
    ncols = eff_dim(cols_cfg, GRID_W);
    nrows = eff_dim(rows_cfg, GRID_H);
    goal = goal_row_cfg * GRID_W + goal_col_cfg;
    goal_ok = (goal_col_cfg < ncols) && (goal_row_cfg < nrows);
    goal_hit = 1'b0;
    dfs_depth = 0;
    if (start_col_cfg >= ncols || start_row_cfg >= nrows) return;
    dfs_stack[0] = start_row_cfg * GRID_W + start_col_cfg;
    mark_bits[dfs_stack[0]] = gmds_pkg::MARK_PATH;
    dfs_depth = 1;
    while (dfs_depth > 0) begin
      top = dfs_stack[dfs_depth-1];
      if (goal_ok && top == goal) begin
        goal_hit = 1'b1;
        break;
      end
      nxt = -1;
      for (d = 0; d < 4 && nxt < 0; d++)
        nxt = open_neighbor(top / GRID_W, top % GRID_W, 2'(d), ncols, nrows);
      if (nxt < 0) begin
        dfs_depth--;
        mark_bits[top] = gmds_pkg::MARK_DONE;
      end else begin
        mark_bits[nxt] = gmds_pkg::MARK_PATH;
        dfs_stack[dfs_depth] = nxt;
        dfs_depth++;
      end
    end
  endfunction

  // apply one item to the mirrored maze and give the result it must produce
  function automatic outcome_t maze_outcome(logic [gmds_pkg::FUNC_W-1:0] f,
                                            logic [gmds_pkg::IDX_W-1:0] idx,
                                            logic [gmds_pkg::DIRS_W-1:0] dirs);
    outcome_t o;
    o.mark = gmds_pkg::MARK_FREE;
    case (f)
      gmds_pkg::FUNC_LOAD: wall_bits[idx] = dirs;
      gmds_pkg::FUNC_CLEAR: begin
        foreach (mark_bits[i]) mark_bits[i] = gmds_pkg::MARK_FREE;
      end
      gmds_pkg::FUNC_RUN: run_dfs();
      gmds_pkg::FUNC_READ: o.mark = mark_bits[idx];
      default: ;
    endcase
    o.hit = goal_hit;
    o.depth = gmds_pkg::LEN_W'(dfs_depth);
    return o;
  endfunction

  // passages biased toward open so searches go deep
  function automatic logic [gmds_pkg::DIRS_W-1:0] rand_dirs();
    if ($urandom_range(0, 1) == 1) return 4'($urandom) | 4'($urandom);
    return 4'($urandom);
  endfunction

  // send one item and hold it until the block takes it
  task automatic send_item(input logic [gmds_pkg::FUNC_W-1:0] f,
                           input logic [gmds_pkg::IDX_W-1:0] idx,
                           input logic [gmds_pkg::DIRS_W-1:0] dirs);
    outcome_t o;
    start <= 1'b1;
    func <= f;
    cell_index <= idx;
    open_dirs <= dirs;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (f == gmds_pkg::FUNC_LOAD) walls_known[idx] = 1'b1;
    o = maze_outcome(f, idx, dirs);
    pending_outcomes = {pending_outcomes, o};
    items_sent++;
    if (f == gmds_pkg::FUNC_RUN) begin
      searches++;
      if (o.hit) goal_searches++;
    end
  endtask

  // random sender gap: mostly none or short, now and then long
  task automatic sender_gap(input bit no_idle);
    int r;
    int n;
    if (no_idle) return;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(15, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending until every pending result is in and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [gmds_pkg::CFG_IDX_W-1:0] idx, input logic [5:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      gmds_pkg::CFG_GRID_COLS: cols_cfg = data;
      gmds_pkg::CFG_GRID_ROWS: rows_cfg = data;
      gmds_pkg::CFG_START_COL: start_col_cfg = data[4:0];
      gmds_pkg::CFG_START_ROW: start_row_cfg = data[4:0];
      gmds_pkg::CFG_GOAL_COL:  goal_col_cfg = data[4:0];
      gmds_pkg::CFG_GOAL_ROW:  goal_row_cfg = data[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [5:0] cols, input logic [5:0] rows,
                            input logic [4:0] sc, input logic [4:0] sr,
                            input logic [4:0] gc, input logic [4:0] gr);
    wait_idle();
    cfg_write(gmds_pkg::CFG_GRID_COLS, cols);
    cfg_write(gmds_pkg::CFG_GRID_ROWS, rows);
    cfg_write(gmds_pkg::CFG_START_COL, {1'b0, sc});
    cfg_write(gmds_pkg::CFG_START_ROW, {1'b0, sr});
    cfg_write(gmds_pkg::CFG_GOAL_COL, {1'b0, gc});
    cfg_write(gmds_pkg::CFG_GOAL_ROW, {1'b0, gr});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // marks after the reset clearing pass
  task automatic test_reset_state();
    send_item(gmds_pkg::FUNC_READ, 10'd0, 4'h0);
    sender_gap(1'b0);
    send_item(gmds_pkg::FUNC_READ, 10'h3FF, 4'hF);
    sender_gap(1'b0);
    send_item(gmds_pkg::FUNC_CLEAR, 10'h155, 4'h5);
    sender_gap(1'b0);
  endtask

  // small known mazes: goal found, start re-marked, clear, ends off the grid, zero columns
  task automatic test_search_cases();
    set_config(6'd2, 6'd2, 5'd0, 5'd0, 5'd1, 5'd1);
    send_item(gmds_pkg::FUNC_LOAD, 10'd0, 4'hF);
    send_item(gmds_pkg::FUNC_LOAD, 10'd1, 4'hF);
    sender_gap(1'b0);
    send_item(gmds_pkg::FUNC_LOAD, 10'd32, 4'hF);
    send_item(gmds_pkg::FUNC_LOAD, 10'd33, 4'hF);
    send_item(gmds_pkg::FUNC_LOAD, 10'h3FF, 4'h0);
    send_item(gmds_pkg::FUNC_READ, 10'h3FF, 4'h0);
    send_item(gmds_pkg::FUNC_RUN, 10'd0, 4'h0);
    send_item(gmds_pkg::FUNC_READ, 10'd33, 4'h0);
    sender_gap(1'b0);
    send_item(gmds_pkg::FUNC_READ, 10'd1, 4'hF);
    // start is still marked from the last search
    send_item(gmds_pkg::FUNC_RUN, 10'h3FF, 4'hF);
    // clear keeps found and depth
    send_item(gmds_pkg::FUNC_CLEAR, 10'd0, 4'h0);
    send_item(gmds_pkg::FUNC_READ, 10'd0, 4'h0);
    // goal off the grid: stack runs dry
    set_config(6'd2, 6'd2, 5'd0, 5'd0, 5'd5, 5'd5);
    send_item(gmds_pkg::FUNC_RUN, 10'd0, 4'h0);
    send_item(gmds_pkg::FUNC_READ, 10'd1, 4'h0);
    // start off the grid: nothing pushed
    set_config(6'd2, 6'd2, 5'd3, 5'd0, 5'd1, 5'd1);
    send_item(gmds_pkg::FUNC_RUN, 10'd0, 4'h0);
    // zero columns saturate to one
    set_config(6'd0, 6'd2, 5'd0, 5'd0, 5'd0, 5'd1);
    send_item(gmds_pkg::FUNC_RUN, 10'd0, 4'h0);
    send_item(gmds_pkg::FUNC_READ, 10'd32, 4'h0);
  endtask

  // random mazes over a series of grid settings, ends swapped halfway
  task automatic test_random_mazes();
    int phase;
    int k;
    int pick;
    int r;
    int c;
    int nc;
    int nr;
    logic [5:0] cols;
    logic [5:0] rows;
    logic [4:0] sc;
    logic [4:0] sr;
    logic [4:0] gc;
    logic [4:0] gr;
    bit no_idle;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        cols = 6'd63; rows = 6'd0; sc = 5'd31; sr = 5'd0; gc = 5'd0; gr = 5'd0;
      end else if (phase == 1) begin
        cols = 6'd1; rows = 6'd32; sc = 5'd0; sr = 5'd31; gc = 5'd0; gr = 5'd0;
      end else begin
        cols = 6'($urandom_range(0, 6));
        rows = 6'($urandom_range(0, 6));
        nc = eff_dim(cols, GRID_W);
        nr = eff_dim(rows, GRID_H);
        sc = 5'($urandom_range(0, nc));
        sr = 5'($urandom_range(0, nr));
        gc = 5'($urandom_range(0, nc));
        gr = 5'($urandom_range(0, nr));
      end
      set_config(cols, rows, sc, sr, gc, gr);
      nc = eff_dim(cols, GRID_W);
      nr = eff_dim(rows, GRID_H);
      no_idle = ($urandom_range(0, 3) == 0);

      // passages for every cell in use that has none yet
      for (r = 0; r < nr; r++)
        for (c = 0; c < nc; c++)
          if (!walls_known[r*GRID_W + c]) begin
            send_item(gmds_pkg::FUNC_LOAD, 10'(r*GRID_W + c), rand_dirs());
            random_items++;
            sender_gap(no_idle);
          end
      send_item(gmds_pkg::FUNC_CLEAR, 10'($urandom), 4'($urandom));
      random_items++;

      for (k = 0; k < PHASE_ITEMS && random_items < RANDOM_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2)
          set_config(cols, rows, gc, gr, sc, sr);
        else if ($urandom_range(0, 19) == 0)
          wait_idle();
        pick = $urandom_range(0, 99);
        r = $urandom_range(0, nr - 1);
        c = $urandom_range(0, nc - 1);
        if (pick < 15)
          send_item(gmds_pkg::FUNC_LOAD, 10'(r*GRID_W + c), rand_dirs());
        else if (pick < 20)
          send_item(gmds_pkg::FUNC_LOAD, 10'($urandom), 4'($urandom));
        else if (pick < 32)
          send_item(gmds_pkg::FUNC_CLEAR, 10'($urandom), 4'($urandom));
        else if (pick < 60)
          send_item(gmds_pkg::FUNC_RUN, 10'($urandom), 4'($urandom));
        else if (pick < 90)
          send_item(gmds_pkg::FUNC_READ, 10'(r*GRID_W + c), 4'($urandom));
        else
          send_item(gmds_pkg::FUNC_READ, 10'($urandom), 4'($urandom));
        random_items++;
        sender_gap(no_idle);
      end
      phase++;
    end
  endtask

  // compare each result with the oldest pending one
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result with no item pending: mark %0d found %0d length %0d",
                   cell_mark, found, path_length);
      end else begin
        want = pending_outcomes.pop_front();
        results_checked++;
        if (cell_mark !== want.mark || found !== want.hit || path_length !== want.depth) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected mark %0d found %0d length %0d, got %0d %0d %0d",
                     results_checked, want.mark, want.hit, want.depth,
                     cell_mark, found, path_length);
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    test_reset_state();
    test_search_cases();
    test_random_mazes();

    wait_idle();
    repeat (40) @(posedge clk);
    if (pending_outcomes.size() != 0)
      $display("%0d results never arrived", pending_outcomes.size());
    $display("%0d items over %0d grid settings, %0d searches of which %0d reached the goal",
             items_sent, settings_used, searches, goal_searches);
    $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
